>>> rtl/core/trme_pkg.sv
// shared types and constants for the tiny register machine executor
// no dependencies; used by the channel interfaces and every module of the block
package trme_pkg;

	localparam int REG_COUNT     = 5;
	localparam int MEM_WORDS     = 50;
	localparam int PROGRAM_LINES = 256;
	localparam int QUEUE_DEPTH   = 2;

	localparam int CMD_W  = 3;
	localparam int KIND_W = 2;
	localparam int REG_W  = 3;
	localparam int ADDR_W = 6;
	localparam int WORD_W = 32;
	localparam int LINE_W = 9;
	localparam int ERR_W  = 2;
	localparam int OP_W   = 4;

	// instruction codes
	localparam logic [CMD_W-1:0] CMD_MOV = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SUB = 3'd2;
	localparam logic [CMD_W-1:0] CMD_JMP = 3'd3;
	localparam logic [CMD_W-1:0] CMD_JPN = 3'd4;
	localparam logic [CMD_W-1:0] CMD_PRN = 3'd5;
	localparam logic [CMD_W-1:0] CMD_HLT = 3'd6;

	// operand kinds
	localparam logic [KIND_W-1:0] KIND_REG  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MEM  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CON  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

	// decoded operations
	localparam logic [OP_W-1:0] OP_ERR  = 4'd0;
	localparam logic [OP_W-1:0] OP_MOVE = 4'd1;
	localparam logic [OP_W-1:0] OP_ADD  = 4'd2;
	localparam logic [OP_W-1:0] OP_SUB  = 4'd3;
	localparam logic [OP_W-1:0] OP_JMP  = 4'd4;
	localparam logic [OP_W-1:0] OP_JZ   = 4'd5;
	localparam logic [OP_W-1:0] OP_JLE  = 4'd6;
	localparam logic [OP_W-1:0] OP_PRN  = 4'd7;
	localparam logic [OP_W-1:0] OP_HLT  = 4'd8;

	// error codes
	localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
	localparam logic [ERR_W-1:0] ERR_FORM   = 2'd1;
	localparam logic [ERR_W-1:0] ERR_TARGET = 2'd2;

	// one classified instruction as it travels from front to back
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [KIND_W-1:0] src_kind;
		logic [REG_W-1:0]  src_reg;
		logic [REG_W-1:0]  a_reg;
		logic [REG_W-1:0]  dst_reg;
		logic [ADDR_W-1:0] mem_addr;
		logic              wr_reg;
		logic              wr_mem;
		logic [WORD_W-1:0] imm;
	} dec_t;

endpackage

>>> rtl/core/trme_if.sv
// valid/ready channel interfaces for instruction items and result items
// depends on trme_pkg for the field widths
interface trme_in_if;
	logic                             valid;
	logic                             ready;
	logic [trme_pkg::CMD_W-1:0]       cmd;
	logic [trme_pkg::KIND_W-1:0]      first_kind;
	logic [trme_pkg::KIND_W-1:0]      second_kind;
	logic [trme_pkg::REG_W-1:0]       first_reg;
	logic [trme_pkg::REG_W-1:0]       second_reg;
	logic [trme_pkg::ADDR_W-1:0]      first_addr;
	logic [trme_pkg::ADDR_W-1:0]      second_addr;
	logic signed [trme_pkg::WORD_W-1:0] constant_value;

	modport source (
		output valid, cmd, first_kind, second_kind, first_reg, second_reg,
		output first_addr, second_addr, constant_value,
		input  ready
	);
	modport sink (
		input  valid, cmd, first_kind, second_kind, first_reg, second_reg,
		input  first_addr, second_addr, constant_value,
		output ready
	);
endinterface

interface trme_out_if;
	logic                         valid;
	logic                         ready;
	logic [trme_pkg::LINE_W-1:0]  next_line;
	logic                         print_valid;
	logic [trme_pkg::WORD_W-1:0]  print_value;
	logic                         print_unsigned;
	logic                         halted;
	logic [trme_pkg::ERR_W-1:0]   error_code;

	modport source (
		output valid, next_line, print_valid, print_value, print_unsigned, halted,
		output error_code,
		input  ready
	);
	modport sink (
		input  valid, next_line, print_valid, print_value, print_unsigned, halted,
		input  error_code,
		output ready
	);
endinterface

>>> rtl/core/trme_front.sv
// front part: accepts instruction items and classifies operand forms
// depends on trme_pkg and trme_in_if
module trme_front (
	trme_in_if.sink          instr,
	output logic             push_valid,
	output trme_pkg::dec_t   push_op,
	input  logic             push_ready
);

	logic k1_ok;
	logic k2_ok;
	logic [trme_pkg::KIND_W-1:0] k1;
	logic [trme_pkg::KIND_W-1:0] k2;

	assign instr.ready = push_ready;
	assign push_valid  = instr.valid;
	assign k1 = instr.first_kind;
	assign k2 = instr.second_kind;

	// register index and address range checks
	always_comb begin
		case (k1)
			trme_pkg::KIND_REG: k1_ok = int'(instr.first_reg) < trme_pkg::REG_COUNT;
			trme_pkg::KIND_MEM: k1_ok = int'(instr.first_addr) < trme_pkg::MEM_WORDS;
			default:            k1_ok = 1'b1;
		endcase
		case (k2)
			trme_pkg::KIND_REG: k2_ok = int'(instr.second_reg) < trme_pkg::REG_COUNT;
			trme_pkg::KIND_MEM: k2_ok = int'(instr.second_addr) < trme_pkg::MEM_WORDS;
			default:            k2_ok = 1'b1;
		endcase
	end

	always_comb begin
		push_op          = '0;
		push_op.op       = trme_pkg::OP_ERR;
		push_op.src_kind = trme_pkg::KIND_CON;
		push_op.imm      = $unsigned(instr.constant_value);
		if (k1_ok && k2_ok) begin
			case (instr.cmd)
				trme_pkg::CMD_MOV: begin
					if (k1 == trme_pkg::KIND_REG && k2 == trme_pkg::KIND_REG) begin
						// copies first into second
						push_op.op       = trme_pkg::OP_MOVE;
						push_op.src_kind = trme_pkg::KIND_REG;
						push_op.src_reg  = instr.first_reg;
						push_op.dst_reg  = instr.second_reg;
						push_op.wr_reg   = 1'b1;
					end else if (k1 == trme_pkg::KIND_REG && k2 == trme_pkg::KIND_CON) begin
						push_op.op       = trme_pkg::OP_MOVE;
						push_op.dst_reg  = instr.first_reg;
						push_op.wr_reg   = 1'b1;
					end else if (k1 == trme_pkg::KIND_REG && k2 == trme_pkg::KIND_MEM) begin
						push_op.op       = trme_pkg::OP_MOVE;
						push_op.src_kind = trme_pkg::KIND_REG;
						push_op.src_reg  = instr.first_reg;
						push_op.mem_addr = instr.second_addr;
						push_op.wr_mem   = 1'b1;
					end else if (k1 == trme_pkg::KIND_MEM && k2 == trme_pkg::KIND_REG) begin
						push_op.op       = trme_pkg::OP_MOVE;
						push_op.src_kind = trme_pkg::KIND_MEM;
						push_op.mem_addr = instr.first_addr;
						push_op.dst_reg  = instr.second_reg;
						push_op.wr_reg   = 1'b1;
					end else if (k1 == trme_pkg::KIND_MEM && k2 == trme_pkg::KIND_CON) begin
						push_op.op       = trme_pkg::OP_MOVE;
						push_op.mem_addr = instr.first_addr;
						push_op.wr_mem   = 1'b1;
					end
				end
				trme_pkg::CMD_ADD, trme_pkg::CMD_SUB: begin
					if (k1 == trme_pkg::KIND_REG && k2 != trme_pkg::KIND_NONE) begin
						push_op.op       = (instr.cmd == trme_pkg::CMD_ADD) ?
						                   trme_pkg::OP_ADD : trme_pkg::OP_SUB;
						push_op.a_reg    = instr.first_reg;
						push_op.dst_reg  = instr.first_reg;
						push_op.wr_reg   = 1'b1;
						push_op.src_kind = k2;
						push_op.src_reg  = instr.second_reg;
						push_op.mem_addr = instr.second_addr;
					end
				end
				trme_pkg::CMD_JMP: begin
					if (k1 == trme_pkg::KIND_REG && k2 == trme_pkg::KIND_CON) begin
						push_op.op    = trme_pkg::OP_JZ;
						push_op.a_reg = instr.first_reg;
					end else if (k1 == trme_pkg::KIND_CON && k2 == trme_pkg::KIND_NONE) begin
						push_op.op    = trme_pkg::OP_JMP;
					end
				end
				trme_pkg::CMD_JPN: begin
					if (k1 == trme_pkg::KIND_REG && k2 == trme_pkg::KIND_CON) begin
						push_op.op    = trme_pkg::OP_JLE;
						push_op.a_reg = instr.first_reg;
					end
				end
				trme_pkg::CMD_PRN: begin
					if (k1 != trme_pkg::KIND_NONE && k2 == trme_pkg::KIND_NONE) begin
						push_op.op       = trme_pkg::OP_PRN;
						push_op.src_kind = k1;
						push_op.src_reg  = instr.first_reg;
						push_op.mem_addr = instr.first_addr;
					end
				end
				trme_pkg::CMD_HLT: begin
					if (k1 == trme_pkg::KIND_NONE && k2 == trme_pkg::KIND_NONE) begin
						push_op.op = trme_pkg::OP_HLT;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/core/trme_queue.sv
// short queue of classified instructions between front and back
// depends on trme_pkg for the entry type and depth
module trme_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  trme_pkg::dec_t push_op,
	output logic           push_ready,
	output logic           pop_valid,
	output trme_pkg::dec_t pop_op,
	input  logic           pop_ready
);

	localparam int PTR_W = (trme_pkg::QUEUE_DEPTH > 1) ? $clog2(trme_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(trme_pkg::QUEUE_DEPTH + 1);

	trme_pkg::dec_t   slot_q [trme_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != CNT_W'(trme_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_op     = slot_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(trme_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(trme_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/trme_back.sv
// back part: operand read stage, execute, machine state and result register
// depends on trme_pkg and trme_out_if
module trme_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	input  trme_pkg::dec_t                pop_op,
	output logic                          pop_ready,
	input  logic [trme_pkg::LINE_W-1:0]   plen,
	trme_out_if.source                    result
);

	localparam int W = trme_pkg::WORD_W;
	localparam int L = trme_pkg::LINE_W;

	// machine state
	logic [W-1:0]                   rf_q   [trme_pkg::REG_COUNT];
	logic [W-1:0]                   mem_q  [trme_pkg::MEM_WORDS];
	logic [trme_pkg::MEM_WORDS-1:0] mvld_q;
	logic [L-1:0]                   line_q;
	logic                           halt_q;

	// operand stage
	logic                 vld_s1;
	trme_pkg::dec_t       op_s1;
	logic [W-1:0]         ra_s1;
	logic [W-1:0]         rs_s1;
	logic [W-1:0]         ram_s1;
	logic                 mvld_s1;
	logic                 fwd_s1;
	logic [W-1:0]         fwd_data_s1;

	// result register
	logic                         res_valid_q;
	logic [L-1:0]                 nl_q;
	logic                         pv_q;
	logic [W-1:0]                 pval_q;
	logic                         puns_q;
	logic                         halted_q;
	logic [trme_pkg::ERR_W-1:0]   err_q;

	logic                         adv;
	logic                         load;
	logic                         run;
	logic                         rf_we;
	logic                         mem_we;
	logic [W-1:0]                 wd;
	logic [W-1:0]                 mem_val;
	logic [W-1:0]                 src_val;
	logic [W-1:0]                 ra_rd;
	logic [W-1:0]                 rs_rd;
	logic                         a_zero;
	logic                         take;
	logic                         tgt_ok;
	logic [L-1:0]                 tgt;
	logic [L-1:0]                 line_inc;
	logic [L-1:0]                 line_d;
	logic                         halt_d;
	logic [trme_pkg::ERR_W-1:0]   err_d;

	assign adv       = !res_valid_q || result.ready;
	assign pop_ready = adv;
	assign load      = adv && pop_valid;
	assign run       = adv && vld_s1 && !halt_q;

	// register reads with bypass of the write in the same edge
	always_comb begin
		ra_rd = (int'(pop_op.a_reg) < trme_pkg::REG_COUNT) ? rf_q[pop_op.a_reg] : '0;
		rs_rd = (int'(pop_op.src_reg) < trme_pkg::REG_COUNT) ? rf_q[pop_op.src_reg] : '0;
		if (rf_we && op_s1.dst_reg == pop_op.a_reg) begin
			ra_rd = wd;
		end
		if (rf_we && op_s1.dst_reg == pop_op.src_reg) begin
			rs_rd = wd;
		end
	end

	// execute
	always_comb begin
		mem_val = fwd_s1 ? fwd_data_s1 : (mvld_s1 ? ram_s1 : '0);
		case (op_s1.src_kind)
			trme_pkg::KIND_REG: src_val = rs_s1;
			trme_pkg::KIND_MEM: src_val = mem_val;
			default:            src_val = op_s1.imm;
		endcase
		case (op_s1.op)
			trme_pkg::OP_ADD: wd = ra_s1 + src_val;
			trme_pkg::OP_SUB: wd = ra_s1 - src_val;
			default:          wd = src_val;
		endcase
		a_zero = ra_s1 == '0;
		case (op_s1.op)
			trme_pkg::OP_JMP: take = 1'b1;
			trme_pkg::OP_JZ:  take = a_zero;
			trme_pkg::OP_JLE: take = a_zero || ra_s1[W-1];
			default:          take = 1'b0;
		endcase
		tgt      = op_s1.imm[L-1:0];
		tgt_ok   = (op_s1.imm[W-1:L] == '0) && (tgt != '0) && (tgt <= plen);
		line_inc = line_q + 1'b1;
		line_d   = line_inc;
		halt_d   = line_inc >= plen;
		err_d    = (op_s1.op == trme_pkg::OP_ERR) ? trme_pkg::ERR_FORM : trme_pkg::ERR_NONE;
		if (take) begin
			if (tgt_ok) begin
				line_d = tgt - 1'b1;
				halt_d = 1'b0;
			end else begin
				line_d = line_q;
				halt_d = 1'b1;
				err_d  = trme_pkg::ERR_TARGET;
			end
		end else if (op_s1.op == trme_pkg::OP_HLT) begin
			line_d = plen;
			halt_d = 1'b1;
		end
		rf_we  = run && op_s1.wr_reg &&
		         (op_s1.op inside {trme_pkg::OP_MOVE, trme_pkg::OP_ADD, trme_pkg::OP_SUB});
		mem_we = run && op_s1.wr_mem && (op_s1.op == trme_pkg::OP_MOVE);
	end

	// data memory and operand stage payload
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[op_s1.mem_addr] <= wd;
		end
		if (load) begin
			op_s1 <= pop_op;
			ra_s1 <= ra_rd;
			rs_s1 <= rs_rd;
			if (pop_op.src_kind == trme_pkg::KIND_MEM) begin
				ram_s1      <= mem_q[pop_op.mem_addr];
				mvld_s1     <= mvld_q[pop_op.mem_addr];
				fwd_s1      <= mem_we && (op_s1.mem_addr == pop_op.mem_addr);
				fwd_data_s1 <= wd;
			end
		end
		if (adv && vld_s1) begin
			if (halt_q) begin
				nl_q     <= line_q;
				pv_q     <= 1'b0;
				pval_q   <= '0;
				puns_q   <= 1'b0;
				halted_q <= 1'b1;
				err_q    <= trme_pkg::ERR_NONE;
			end else begin
				nl_q     <= line_d;
				pv_q     <= op_s1.op == trme_pkg::OP_PRN;
				pval_q   <= (op_s1.op == trme_pkg::OP_PRN) ? src_val : '0;
				puns_q   <= (op_s1.op == trme_pkg::OP_PRN) &&
				            (op_s1.src_kind == trme_pkg::KIND_MEM);
				halted_q <= halt_d;
				err_q    <= err_d;
			end
		end
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			res_valid_q <= 1'b0;
			line_q      <= '0;
			halt_q      <= 1'b0;
			mvld_q      <= '0;
			for (int i = 0; i < trme_pkg::REG_COUNT; i++) begin
				rf_q[i] <= '0;
			end
		end else begin
			if (adv) begin
				vld_s1      <= pop_valid;
				res_valid_q <= vld_s1;
			end
			if (run) begin
				line_q <= line_d;
				halt_q <= halt_d;
			end
			if (rf_we) begin
				rf_q[op_s1.dst_reg] <= wd;
			end
			if (mem_we) begin
				mvld_q[op_s1.mem_addr] <= 1'b1;
			end
		end
	end

	assign result.valid          = res_valid_q;
	assign result.next_line      = nl_q;
	assign result.print_valid    = pv_q;
	assign result.print_value    = pval_q;
	assign result.print_unsigned = puns_q;
	assign result.halted         = halted_q;
	assign result.error_code     = err_q;

endmodule

>>> rtl/core/tiny_register_machine_executor.sv
// top level of the tiny register machine executor: front, queue, back and length register
// depends on trme_pkg, trme_if, trme_front, trme_queue and trme_back
//
// usage
// - instr carries one decoded instruction per item (valid/ready); result returns
//   exactly one item per instruction, in order, with the next 0-based line to fetch,
//   an optional printed word, the halt flag and an error code
// - cfg_we/cfg_data write program_length (0 reads as 1, above 256 as 256);
//   write it only while no instruction is in flight
// - an accepted item passes the queue, the operand stage and the result register
// - throughput: one item per cycle sustained while result items are taken; the execute
//   stage does one register or memory read-modify-write per cycle and bypasses a
//   write to the operand read that happens at the same edge
// - a result that is not taken holds the execute stage; the two-entry queue then
//   fills and instr.ready drops, so nothing is lost or repeated
// - reset clears the registers, the memory valid bits (so every word reads zero),
//   the line counter and the halt flag, and sets program_length to 1; no sweep is
//   needed and items are accepted right after reset
// - once halted, every further item returns the held line with halted set
module tiny_register_machine_executor (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [trme_pkg::LINE_W-1:0]  cfg_data,
	trme_in_if.sink                      instr,
	trme_out_if.source                   result
);

	logic [trme_pkg::LINE_W-1:0] plen_q;
	logic                        push_valid;
	logic                        push_ready;
	trme_pkg::dec_t              push_op;
	logic                        pop_valid;
	logic                        pop_ready;
	trme_pkg::dec_t              pop_op;

	// program length register, saturated to the supported line range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= trme_pkg::LINE_W'(1);
		end else if (cfg_we) begin
			if (cfg_data == '0) begin
				plen_q <= trme_pkg::LINE_W'(1);
			end else if (cfg_data > trme_pkg::LINE_W'(trme_pkg::PROGRAM_LINES)) begin
				plen_q <= trme_pkg::LINE_W'(trme_pkg::PROGRAM_LINES);
			end else begin
				plen_q <= cfg_data;
			end
		end
	end

	// classify operand forms on entry
	trme_front u_front (
		.instr      (instr),
		.push_valid (push_valid),
		.push_op    (push_op),
		.push_ready (push_ready)
	);

	// decouples acceptance from execution
	trme_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_op    (push_op),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_op     (pop_op),
		.pop_ready  (pop_ready)
	);

	// operand read, execute and result register
	trme_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_op    (pop_op),
		.pop_ready (pop_ready),
		.plen      (plen_q),
		.result    (result)
	);

endmodule

>>> test/tb_top.sv
// self-checking testbench for tiny_register_machine_executor
// keeps its own model of the machine and checks each result item against it or against a typed script expectation
// depends on trme_pkg, trme_if and the rtl of the block
module tb_top;

	// package constants used throughout the bench
	localparam int REG_COUNT     = trme_pkg::REG_COUNT;
	localparam int MEM_WORDS     = trme_pkg::MEM_WORDS;
	localparam int PROGRAM_LINES = trme_pkg::PROGRAM_LINES;
	localparam int CMD_W         = trme_pkg::CMD_W;
	localparam int KIND_W        = trme_pkg::KIND_W;
	localparam int REG_W         = trme_pkg::REG_W;
	localparam int ADDR_W        = trme_pkg::ADDR_W;
	localparam int WORD_W        = trme_pkg::WORD_W;
	localparam int LINE_W        = trme_pkg::LINE_W;
	localparam int ERR_W         = trme_pkg::ERR_W;

	localparam logic [CMD_W-1:0] CMD_MOV = trme_pkg::CMD_MOV;
	localparam logic [CMD_W-1:0] CMD_ADD = trme_pkg::CMD_ADD;
	localparam logic [CMD_W-1:0] CMD_SUB = trme_pkg::CMD_SUB;
	localparam logic [CMD_W-1:0] CMD_JMP = trme_pkg::CMD_JMP;
	localparam logic [CMD_W-1:0] CMD_JPN = trme_pkg::CMD_JPN;
	localparam logic [CMD_W-1:0] CMD_PRN = trme_pkg::CMD_PRN;
	localparam logic [CMD_W-1:0] CMD_HLT = trme_pkg::CMD_HLT;

	localparam logic [KIND_W-1:0] KIND_REG  = trme_pkg::KIND_REG;
	localparam logic [KIND_W-1:0] KIND_MEM  = trme_pkg::KIND_MEM;
	localparam logic [KIND_W-1:0] KIND_CON  = trme_pkg::KIND_CON;
	localparam logic [KIND_W-1:0] KIND_NONE = trme_pkg::KIND_NONE;

	localparam logic [ERR_W-1:0] ERR_NONE   = trme_pkg::ERR_NONE;
	localparam logic [ERR_W-1:0] ERR_FORM   = trme_pkg::ERR_FORM;
	localparam logic [ERR_W-1:0] ERR_TARGET = trme_pkg::ERR_TARGET;

	// cmd value that no instruction uses
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
	// watchdog, far above the slowest legal run
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 80;

	// one instruction item as it is driven
	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [KIND_W-1:0] first_kind;
		logic [KIND_W-1:0] second_kind;
		logic [REG_W-1:0]  first_reg;
		logic [REG_W-1:0]  second_reg;
		logic [ADDR_W-1:0] first_addr;
		logic [ADDR_W-1:0] second_addr;
		logic [WORD_W-1:0] constant_value;
	} instr_item_t;

	// one result item as it comes back
	typedef struct packed {
		logic [LINE_W-1:0] next_line;
		logic              print_valid;
		logic [WORD_W-1:0] print_value;
		logic              print_unsigned;
		logic              halted;
		logic [ERR_W-1:0]  error_code;
	} exec_result_t;

	// architectural state of the machine
	typedef struct packed {
		logic [REG_COUNT-1:0][WORD_W-1:0] regs;
		logic [MEM_WORDS-1:0][WORD_W-1:0] mem;
		logic [LINE_W-1:0]                line;
		logic                             halted;
	} machine_t;

	// one line of the directed script: either a length write or an instruction
	typedef struct packed {
		logic              is_write;
		logic [LINE_W-1:0] len_value;
		instr_item_t       item;
		logic              typed;
		exec_result_t      want;
	} script_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [LINE_W-1:0] cfg_data;

	trme_in_if  instr_ch ();
	trme_out_if result_ch ();

	tiny_register_machine_executor dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.instr   (instr_ch),
		.result  (result_ch)
	);

	// predicted machine and length register, advanced at each accepted item
	machine_t          mach;
	logic [LINE_W-1:0] prog_len;
	exec_result_t      pending_results[$];
	script_row_t       script[$];

	int send_idle_pct;
	int stall_pct;
	bit hold_req;
	int hold_left;
	int mismatches;
	int cycle_count;

	// clock, period of two units
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// ---------------------------------------------------------------
	// machine model
	// ---------------------------------------------------------------

	function automatic logic operand_ok(logic [KIND_W-1:0] kind, logic [REG_W-1:0] r,
			logic [ADDR_W-1:0] a);
		if (kind == KIND_REG) return r < REG_COUNT;
		if (kind == KIND_MEM) return a < MEM_WORDS;
		return 1'b1;
	endfunction

	function automatic logic [WORD_W-1:0] operand_word(machine_t m, logic [KIND_W-1:0] kind,
			logic [REG_W-1:0] r, logic [ADDR_W-1:0] a, logic [WORD_W-1:0] c);
		if (kind == KIND_REG) return m.regs[r];
		if (kind == KIND_MEM) return m.mem[a];
		return c;
	endfunction

	// saturate a written length into 1..PROGRAM_LINES
	function automatic logic [LINE_W-1:0] clamp_len(logic [LINE_W-1:0] v);
		if (v == 0) return LINE_W'(1);
		if (v > PROGRAM_LINES) return LINE_W'(PROGRAM_LINES);
		return v;
	endfunction

	// executes one instruction on m and gives the result item it produces
	function automatic void execute_instr(inout machine_t m, input instr_item_t it,
			input logic [LINE_W-1:0] len, output exec_result_t o);
		logic [KIND_W-1:0] k1;
		logic [KIND_W-1:0] k2;
		logic [REG_W-1:0]  r1;
		logic [REG_W-1:0]  r2;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] w;
		logic take;
		logic stop;
		k1 = it.first_kind;
		k2 = it.second_kind;
		r1 = it.first_reg;
		r2 = it.second_reg;
		c = it.constant_value;
		o = '0;
		take = 1'b0;
		stop = 1'b0;
		// a halted machine ignores the item and repeats its line
		if (m.halted) begin
			o.next_line = m.line;
			o.halted = 1'b1;
			return;
		end
		if (!operand_ok(k1, r1, it.first_addr) || !operand_ok(k2, r2, it.second_addr)) begin
			o.error_code = ERR_FORM;
		end else begin
			case (it.cmd)
				CMD_MOV: begin
					// register to register copies first into second
					if (k1 == KIND_REG && k2 == KIND_REG) m.regs[r2] = m.regs[r1];
					else if (k1 == KIND_REG && k2 == KIND_CON) m.regs[r1] = c;
					else if (k1 == KIND_REG && k2 == KIND_MEM) m.mem[it.second_addr] = m.regs[r1];
					else if (k1 == KIND_MEM && k2 == KIND_REG) m.regs[r2] = m.mem[it.first_addr];
					else if (k1 == KIND_MEM && k2 == KIND_CON) m.mem[it.first_addr] = c;
					else o.error_code = ERR_FORM;
				end
				CMD_ADD, CMD_SUB: begin
					if (k1 == KIND_REG && k2 != KIND_NONE) begin
						w = operand_word(m, k2, r2, it.second_addr, c);
						m.regs[r1] = (it.cmd == CMD_ADD) ? m.regs[r1] + w : m.regs[r1] - w;
					end else begin
						o.error_code = ERR_FORM;
					end
				end
				CMD_JMP: begin
					if (k1 == KIND_REG && k2 == KIND_CON) take = (m.regs[r1] == 0);
					else if (k1 == KIND_CON && k2 == KIND_NONE) take = 1'b1;
					else o.error_code = ERR_FORM;
				end
				CMD_JPN: begin
					// at most zero, read as signed
					if (k1 == KIND_REG && k2 == KIND_CON)
						take = (m.regs[r1] == 0) || m.regs[r1][WORD_W-1];
					else
						o.error_code = ERR_FORM;
				end
				CMD_PRN: begin
					if (k1 != KIND_NONE && k2 == KIND_NONE) begin
						o.print_valid = 1'b1;
						o.print_value = operand_word(m, k1, r1, it.first_addr, c);
						o.print_unsigned = (k1 == KIND_MEM);
					end else begin
						o.error_code = ERR_FORM;
					end
				end
				CMD_HLT: begin
					if (k1 == KIND_NONE && k2 == KIND_NONE) stop = 1'b1;
					else o.error_code = ERR_FORM;
				end
				default: o.error_code = ERR_FORM;
			endcase
		end
		if (take) begin
			// 1-based target, checked only when the jump is taken
			if (!c[WORD_W-1] && c != 0 && c <= {{(WORD_W-LINE_W){1'b0}}, len}) begin
				m.line = LINE_W'(c - 1);
			end else begin
				o.error_code = ERR_TARGET;
				m.halted = 1'b1;
			end
		end else if (stop) begin
			m.halted = 1'b1;
			m.line = len;
		end else begin
			m.line = m.line + 1'b1;
			if (m.line >= len) m.halted = 1'b1;
		end
		o.next_line = m.line;
		o.halted = m.halted;
	endfunction

	// ---------------------------------------------------------------
	// item construction
	// ---------------------------------------------------------------

	function automatic instr_item_t ins(logic [CMD_W-1:0] cmd, logic [KIND_W-1:0] k1,
			logic [KIND_W-1:0] k2, logic [REG_W-1:0] r1, logic [REG_W-1:0] r2,
			logic [ADDR_W-1:0] a1, logic [ADDR_W-1:0] a2, logic [WORD_W-1:0] c);
		return '{cmd, k1, k2, r1, r2, a1, a2, c};
	endfunction

	function automatic exec_result_t res(logic [LINE_W-1:0] line, logic pv,
			logic [WORD_W-1:0] pval, logic puns, logic h, logic [ERR_W-1:0] e);
		return '{line, pv, pval, puns, h, e};
	endfunction

	// every field over its full width, so every bit toggles
	function automatic instr_item_t noise_instr();
		return ins(CMD_W'($urandom()), KIND_W'($urandom()), KIND_W'($urandom()),
			REG_W'($urandom()), REG_W'($urandom()), ADDR_W'($urandom()),
			ADDR_W'($urandom()), $urandom());
	endfunction

	// operand words lean on the wrap points
	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(6))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hFFFF_FFFF;
			3: return 32'h7FFF_FFFF;
			4: return 32'h8000_0000;
			default: return $urandom();
		endcase
	endfunction

	// mostly legal targets, sometimes zero, one past the end or anything
	function automatic logic [WORD_W-1:0] pick_target(logic [LINE_W-1:0] len);
		case ($urandom_range(9))
			7: return 32'd0;
			8: return {{(WORD_W-LINE_W){1'b0}}, len} + 1;
			9: return $urandom();
			default: return $urandom_range(len, 1);
		endcase
	endfunction

	function automatic logic [KIND_W-1:0] pick_source_kind();
		case ($urandom_range(2))
			0: return KIND_REG;
			1: return KIND_MEM;
			default: return KIND_CON;
		endcase
	endfunction

	// legal form with random contents; unused fields keep their noise
	function automatic instr_item_t wellformed_instr(logic [LINE_W-1:0] len);
		instr_item_t it;
		it = noise_instr();
		it.first_reg = REG_W'($urandom_range(REG_COUNT - 1));
		it.second_reg = REG_W'($urandom_range(REG_COUNT - 1));
		it.first_addr = ADDR_W'($urandom_range(MEM_WORDS - 1));
		it.second_addr = ADDR_W'($urandom_range(MEM_WORDS - 1));
		it.constant_value = pick_word();
		case ($urandom_range(5))
			0: begin
				it.cmd = CMD_MOV;
				case ($urandom_range(4))
					0: begin it.first_kind = KIND_REG; it.second_kind = KIND_REG; end
					1: begin it.first_kind = KIND_REG; it.second_kind = KIND_CON; end
					2: begin it.first_kind = KIND_REG; it.second_kind = KIND_MEM; end
					3: begin it.first_kind = KIND_MEM; it.second_kind = KIND_REG; end
					default: begin it.first_kind = KIND_MEM; it.second_kind = KIND_CON; end
				endcase
			end
			1, 2: begin
				it.cmd = ($urandom_range(1) != 0) ? CMD_ADD : CMD_SUB;
				it.first_kind = KIND_REG;
				it.second_kind = pick_source_kind();
			end
			3: begin
				it.cmd = CMD_JMP;
				it.constant_value = pick_target(len);
				if ($urandom_range(1) != 0) begin
					it.first_kind = KIND_REG;
					it.second_kind = KIND_CON;
				end else begin
					it.first_kind = KIND_CON;
					it.second_kind = KIND_NONE;
				end
			end
			4: begin
				it.cmd = CMD_JPN;
				it.constant_value = pick_target(len);
				it.first_kind = KIND_REG;
				it.second_kind = KIND_CON;
			end
			default: begin
				it.cmd = CMD_PRN;
				it.first_kind = pick_source_kind();
				it.second_kind = KIND_NONE;
			end
		endcase
		return it;
	endfunction

	// unconditional jump to a legal line
	function automatic instr_item_t jump_back(logic [LINE_W-1:0] len);
		instr_item_t it;
		it = noise_instr();
		it.cmd = CMD_JMP;
		it.first_kind = KIND_CON;
		it.second_kind = KIND_NONE;
		it.constant_value = $urandom_range(len, 1);
		return it;
	endfunction

	// next random item, chosen so that the machine keeps running: a halt can only
	// be left by reset, so halting items are saved for the very end of the run
	function automatic instr_item_t plan_instr();
		instr_item_t it;
		machine_t trial;
		exec_result_t scratch;
		if (mach.line + 1 >= prog_len) return jump_back(prog_len);
		repeat (20) begin
			it = ($urandom_range(99) < 80) ? wellformed_instr(prog_len) : noise_instr();
			trial = mach;
			execute_instr(trial, it, prog_len, scratch);
			if (!trial.halted) return it;
		end
		return jump_back(prog_len);
	endfunction

	// ---------------------------------------------------------------
	// driving
	// ---------------------------------------------------------------

	// offers one item from a falling edge, with random idle cycles ahead of it,
	// and records the expected result once it is taken
	task automatic issue(input instr_item_t it, input logic typed, input exec_result_t want);
		exec_result_t o;
		while ($urandom_range(99) < send_idle_pct) begin
			instr_ch.valid <= 1'b0;
			@(negedge clk);
		end
		instr_ch.valid          <= 1'b1;
		instr_ch.cmd            <= it.cmd;
		instr_ch.first_kind     <= it.first_kind;
		instr_ch.second_kind    <= it.second_kind;
		instr_ch.first_reg      <= it.first_reg;
		instr_ch.second_reg     <= it.second_reg;
		instr_ch.first_addr     <= it.first_addr;
		instr_ch.second_addr    <= it.second_addr;
		instr_ch.constant_value <= it.constant_value;
		do @(posedge clk); while (!instr_ch.ready);
		execute_instr(mach, it, prog_len, o);
		pending_results.push_back(typed ? want : o);
		@(negedge clk);
	endtask

	// length write, only once every result is back
	task automatic write_len(input logic [LINE_W-1:0] v);
		instr_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		prog_len = clamp_len(v);
	endtask

	// idling mix changes just after a rising edge so the receiver sees it cleanly
	task automatic set_phase(input int send_pct, input int recv_pct, input bit hold);
		@(posedge clk);
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
		hold_req = hold;
		@(negedge clk);
	endtask

	// receiver: random stalls, or a long counted hold-off when asked
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = 60;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			result_ch.ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// ---------------------------------------------------------------
	// checking
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		exec_result_t got;
		exec_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = '{result_ch.next_line, result_ch.print_valid, result_ch.print_value,
				result_ch.print_unsigned, result_ch.halted, result_ch.error_code};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item: line %0d print %0b/%h/%0b halt %0b err %0d",
						got.next_line, got.print_valid, got.print_value, got.print_unsigned,
						got.halted, got.error_code);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result mismatch at cycle %0d", cycle_count);
						$display("  expected line %0d print %0b/%h/%0b halt %0b err %0d",
							want.next_line, want.print_valid, want.print_value,
							want.print_unsigned, want.halted, want.error_code);
						$display("  actual   line %0d print %0b/%h/%0b halt %0b err %0d",
							got.next_line, got.print_valid, got.print_value,
							got.print_unsigned, got.halted, got.error_code);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tiny_register_machine_executor regression: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------

	initial begin
		// every input known from time zero
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		instr_ch.valid = 1'b0;
		instr_ch.cmd = '0;
		instr_ch.first_kind = '0;
		instr_ch.second_kind = '0;
		instr_ch.first_reg = '0;
		instr_ch.second_reg = '0;
		instr_ch.first_addr = '0;
		instr_ch.second_addr = '0;
		instr_ch.constant_value = '0;
		result_ch.ready = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		hold_left = 0;
		mismatches = 0;
		cycle_count = 0;
		mach = '0;
		prog_len = LINE_W'(1);

		// directed script; typed expectations where the result is plain to see
		// with the reset length of one, only a jump to line 1 keeps running
		script.push_back('{1'b0, 9'd0, ins(CMD_JMP, KIND_CON, KIND_NONE, 0, 0, 0, 0, 1),
			1'b1, res(0, 0, 0, 0, 0, ERR_NONE)});
		// zero saturates to one
		script.push_back('{1'b1, 9'd0, '0, 1'b0, '0});
		script.push_back('{1'b0, 9'd0, ins(CMD_JMP, KIND_CON, KIND_NONE, 0, 0, 0, 0, 1),
			1'b1, res(0, 0, 0, 0, 0, ERR_NONE)});
		// all ones saturates to the full program
		script.push_back('{1'b1, 9'h1FF, '0, 1'b0, '0});
		// bad operand forms: error, nothing written, line still advances
		script.push_back('{1'b0, 9'd0, ins(CMD_ADD, KIND_REG, KIND_CON, 5, 0, 0, 0, 1),
			1'b1, res(1, 0, 0, 0, 0, ERR_FORM)});
		script.push_back('{1'b0, 9'd0, ins(CMD_MOV, KIND_REG, KIND_REG, 0, 7, 0, 0, 0),
			1'b1, res(2, 0, 0, 0, 0, ERR_FORM)});
		script.push_back('{1'b0, 9'd0, ins(CMD_PRN, KIND_MEM, KIND_NONE, 0, 0, 50, 0, 0),
			1'b1, res(3, 0, 0, 0, 0, ERR_FORM)});
		script.push_back('{1'b0, 9'd0, ins(CMD_ADD, KIND_REG, KIND_MEM, 0, 0, 0, 63, 0),
			1'b1, res(4, 0, 0, 0, 0, ERR_FORM)});
		script.push_back('{1'b0, 9'd0, ins(CMD_UNUSED, KIND_REG, KIND_REG, 0, 0, 0, 0, 0),
			1'b1, res(5, 0, 0, 0, 0, ERR_FORM)});
		script.push_back('{1'b0, 9'd0, ins(CMD_MOV, KIND_CON, KIND_REG, 0, 0, 0, 0, 9),
			1'b1, res(6, 0, 0, 0, 0, ERR_FORM)});
		script.push_back('{1'b0, 9'd0, ins(CMD_HLT, KIND_REG, KIND_NONE, 0, 0, 0, 0, 0),
			1'b1, res(7, 0, 0, 0, 0, ERR_FORM)});
		script.push_back('{1'b0, 9'd0, ins(CMD_ADD, KIND_REG, KIND_NONE, 0, 0, 0, 0, 0),
			1'b1, res(8, 0, 0, 0, 0, ERR_FORM)});
		script.push_back('{1'b0, 9'd0, ins(CMD_PRN, KIND_NONE, KIND_NONE, 0, 0, 0, 0, 0),
			1'b1, res(9, 0, 0, 0, 0, ERR_FORM)});
		// jump to the last line and straight back to the first
		script.push_back('{1'b0, 9'd0, ins(CMD_JMP, KIND_CON, KIND_NONE, 0, 0, 0, 0, 256),
			1'b1, res(255, 0, 0, 0, 0, ERR_NONE)});
		script.push_back('{1'b0, 9'd0, ins(CMD_JMP, KIND_CON, KIND_NONE, 0, 0, 0, 0, 1),
			1'b1, res(0, 0, 0, 0, 0, ERR_NONE)});
		// arithmetic wrap, every move form, prints and jumps
		script.push_back('{1'b0, 9'd0,
			ins(CMD_MOV, KIND_REG, KIND_CON, 0, 0, 0, 0, 32'h7FFF_FFFF), 1'b0, '0});
		script.push_back('{1'b0, 9'd0,
			ins(CMD_MOV, KIND_REG, KIND_CON, 4, 0, 0, 0, 32'h8000_0000), 1'b0, '0});
		script.push_back('{1'b0, 9'd0, ins(CMD_ADD, KIND_REG, KIND_REG, 0, 4, 0, 0, 0),
			1'b0, '0});
		script.push_back('{1'b0, 9'd0, ins(CMD_ADD, KIND_REG, KIND_CON, 0, 0, 0, 0, 1),
			1'b0, '0});
		script.push_back('{1'b0, 9'd0, ins(CMD_MOV, KIND_REG, KIND_MEM, 4, 0, 0, 49, 0),
			1'b0, '0});
		script.push_back('{1'b0, 9'd0, ins(CMD_MOV, KIND_MEM, KIND_REG, 0, 3, 49, 0, 0),
			1'b0, '0});
		script.push_back('{1'b0, 9'd0,
			ins(CMD_MOV, KIND_MEM, KIND_CON, 0, 0, 0, 0, 32'hFFFF_FFFF), 1'b0, '0});
		script.push_back('{1'b0, 9'd0, ins(CMD_SUB, KIND_REG, KIND_MEM, 3, 0, 0, 0, 0),
			1'b0, '0});
		script.push_back('{1'b0, 9'd0, ins(CMD_MOV, KIND_REG, KIND_REG, 4, 2, 0, 0, 0),
			1'b0, '0});
		script.push_back('{1'b0, 9'd0, ins(CMD_PRN, KIND_MEM, KIND_NONE, 0, 0, 49, 0, 0),
			1'b0, '0});
		script.push_back('{1'b0, 9'd0, ins(CMD_PRN, KIND_REG, KIND_NONE, 2, 0, 0, 0, 0),
			1'b0, '0});
		// taken on zero, not taken with a target that would be illegal
		script.push_back('{1'b0, 9'd0, ins(CMD_JMP, KIND_REG, KIND_CON, 0, 0, 0, 0, 3),
			1'b0, '0});
		script.push_back('{1'b0, 9'd0, ins(CMD_JMP, KIND_REG, KIND_CON, 4, 0, 0, 0, 0),
			1'b0, '0});
		// negative register jumps
		script.push_back('{1'b0, 9'd0, ins(CMD_JPN, KIND_REG, KIND_CON, 2, 0, 0, 0, 1),
			1'b0, '0});

		// reset held from time zero, released on a falling edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			if (script[i].is_write) write_len(script[i].len_value);
			else issue(script[i].item, script[i].typed, script[i].want);
		end

		// random phases, each with its own length and idling mix
		write_len(9'd256);
		set_phase(0, 0, 1'b0);
		repeat (PHASE_ITEMS) issue(plan_instr(), 1'b0, '0);

		// short program: frequent wrap jumps
		write_len(LINE_W'($urandom_range(12, 2)));
		set_phase(87, 0, 1'b0);
		repeat (PHASE_ITEMS) issue(plan_instr(), 1'b0, '0);

		write_len(9'd300);
		set_phase(0, 87, 1'b0);
		repeat (PHASE_ITEMS) issue(plan_instr(), 1'b0, '0);

		write_len(LINE_W'($urandom_range(511, 0)));
		set_phase(16, 16, 1'b0);
		repeat (PHASE_ITEMS) issue(plan_instr(), 1'b0, '0);

		// back-pressure: receiver holds off while items keep coming
		write_len(LINE_W'($urandom_range(256, 2)));
		set_phase(0, 0, 1'b1);
		repeat (40) issue(plan_instr(), 1'b0, '0);

		// a halt only clears on reset, so one way of halting ends the run
		case ($urandom_range(3))
			0: issue(ins(CMD_HLT, KIND_NONE, KIND_NONE, REG_W'($urandom()), REG_W'($urandom()),
				ADDR_W'($urandom()), ADDR_W'($urandom()), $urandom()), 1'b0, '0);
			1: begin
				// taken jump to a line outside the program
				case ($urandom_range(2))
					0: issue(ins(CMD_JMP, KIND_CON, KIND_NONE, 0, 0, 0, 0, 0), 1'b0, '0);
					1: issue(ins(CMD_JMP, KIND_CON, KIND_NONE, 0, 0, 0, 0, 32'h8000_0000),
						1'b0, '0);
					default: issue(ins(CMD_JMP, KIND_CON, KIND_NONE, 0, 0, 0, 0,
						{{(WORD_W-LINE_W){1'b0}}, prog_len} + 1), 1'b0, '0);
				endcase
			end
			2: begin
				// run off the end of the program from its last line
				issue(ins(CMD_JMP, KIND_CON, KIND_NONE, 0, 0, 0, 0,
					{{(WORD_W-LINE_W){1'b0}}, prog_len}), 1'b0, '0);
				while (!mach.halted)
					issue(ins(CMD_MOV, KIND_REG, KIND_CON, REG_W'($urandom_range(REG_COUNT - 1)),
						0, 0, 0, $urandom()), 1'b0, '0);
			end
			default: begin
				// shrink the program under the current line
				write_len(mach.line);
				issue(ins(CMD_ADD, KIND_REG, KIND_CON, REG_W'($urandom_range(REG_COUNT - 1)),
					0, 0, 0, $urandom()), 1'b0, '0);
			end
		endcase
		// halted: everything is ignored from here on
		repeat (10) issue(noise_instr(), 1'b0, '0);
		instr_ch.valid <= 1'b0;

		// drain, then keep watching to catch stray results
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("tiny_register_machine_executor regression: pass");
		end else begin
			$display("tiny_register_machine_executor regression: fail");
		end
		$finish;
	end

endmodule
